// ----- rtl/mcst_pkg.sv -----
// Shared types and constants for the min-count segment tree unit.
package mcst_pkg;

    localparam int ValueWidth = 48;
    localparam int PosWidth   = 11;
    localparam int KindWidth  = 2;
    localparam int InDataWidth  = 136;
    localparam int OutDataWidth = 72;

    localparam logic signed [ValueWidth-1:0] EMPTY_MIN = 48'sh7FFF_FFFF_FFFF;

    localparam logic [KindWidth-1:0] KIND_INSERT = 2'd0;
    localparam logic [KindWidth-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KindWidth-1:0] KIND_SEARCH = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_INS_LEAF,
        ST_INS_CHK,
        ST_INS_WR,
        ST_Q_CHK,
        ST_Q_COMB,
        ST_S_RD,
        ST_S_CMP,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic cfg_wr;
        logic clr_step;
        logic ins_leaf;
        logic ins_rd;
        logic ins_wr;
        logic q_rd;
        logic q_comb;
        logic s_rd;
        logic s_cmp;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic                 clr_done;
        logic [KindWidth-1:0] kind;
        logic                 ins_ok;
        logic                 range_ok;
        logic                 idx_gt1;
        logic                 l_lt_r;
        logic                 s_hit;
        logic                 s_more;
        logic                 out_busy;
    } status_t;

endpackage

// ----- rtl/mcst_ctrl.sv -----
// Controller state machine sequencing clear, insert, query and search.
module mcst_ctrl
    import mcst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    cfg_valid,
    input  status_t status,
    output logic    in_ready,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = !cfg_valid;
                if (in_valid && !cfg_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.kind)
                    KIND_INSERT: state_next = status.ins_ok ? ST_INS_LEAF : ST_RESP;
                    KIND_QUERY:  state_next = status.range_ok ? ST_Q_CHK : ST_RESP;
                    KIND_SEARCH: state_next = status.range_ok ? ST_S_RD : ST_RESP;
                    default:     state_next = ST_RESP;
                endcase
            end
            ST_INS_LEAF:
            begin
                cmd.ins_leaf = 1'b1;
                state_next   = ST_INS_CHK;
            end
            ST_INS_CHK:
            begin
                if (status.idx_gt1)
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = ST_INS_WR;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                state_next = ST_INS_CHK;
            end
            ST_Q_CHK:
            begin
                if (status.l_lt_r)
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = ST_Q_COMB;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_Q_COMB:
            begin
                cmd.q_comb = 1'b1;
                state_next = ST_Q_CHK;
            end
            ST_S_RD:
            begin
                cmd.s_rd   = 1'b1;
                state_next = ST_S_CMP;
            end
            ST_S_CMP:
            begin
                cmd.s_cmp  = 1'b1;
                state_next = (status.s_hit || !status.s_more) ? ST_RESP : ST_S_RD;
            end
            ST_RESP:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        cmd.cfg_wr = cfg_valid;
        if (cfg_valid)
        begin
            state_next = ST_CLEAR;
        end
    end

endmodule

// ----- rtl/mcst_dpath.sv -----
// Datapath with node memory, range pointers, accumulator and result register.
module mcst_dpath
    import mcst_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output status_t                      status,
    input  logic [PosWidth-1:0]          cfg_value,
    input  logic [KindWidth-1:0]         in_kind,
    input  logic [PosWidth-1:0]          in_position,
    input  logic signed [ValueWidth-1:0] in_leaf_value,
    input  logic [PosWidth-1:0]          in_range_low,
    input  logic [PosWidth-1:0]          in_range_high,
    input  logic signed [ValueWidth-1:0] in_threshold,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic signed [ValueWidth-1:0] out_min_value,
    output logic [PosWidth-1:0]          out_min_count,
    output logic                         out_found,
    output logic [PosWidth-1:0]          out_found_position
);

    localparam int AW = $clog2(2 * LEAVES);
    localparam int IW = AW + 1;
    localparam int CW = $clog2(LEAVES + 1);
    localparam int Depth = 2 * LEAVES;
    localparam int LiuReset = (LEAVES < 1024) ? LEAVES : 1024;

    typedef struct packed {
        logic signed [ValueWidth-1:0] m;
        logic [CW-1:0]                c;
    } node_t;

    function automatic node_t combine(input node_t x, input node_t y);
        node_t r;
        r = x;
        if (y.m < x.m)
        begin
            r = y;
        end
        else if (y.m == x.m)
        begin
            r.c = x.c + y.c;
        end
        return r;
    endfunction

    logic signed [ValueWidth-1:0] mem_min [Depth];
    logic [CW-1:0]                mem_cnt [Depth];

    logic [PosWidth-1:0]          liu_reg;
    logic [AW-1:0]                clr_cnt_reg;
    logic [KindWidth-1:0]         kind_reg;
    logic [PosWidth-1:0]          pos_reg;
    logic signed [ValueWidth-1:0] val_reg;
    logic signed [ValueWidth-1:0] thr_reg;
    logic [PosWidth-1:0]          lo_reg;
    logic [PosWidth-1:0]          hi_reg;
    logic [IW-1:0]                idx_reg;
    logic [IW-1:0]                l_reg;
    logic [IW-1:0]                r_reg;
    node_t                        acc_reg;
    node_t                        rda_reg;
    node_t                        rdb_reg;
    logic                         found_reg;
    logic [PosWidth-1:0]          fpos_reg;
    logic                         out_valid_reg;
    logic signed [ValueWidth-1:0] out_min_reg;
    logic [PosWidth-1:0]          out_cnt_reg;
    logic                         out_found_reg;
    logic [PosWidth-1:0]          out_fpos_reg;

    logic [PosWidth-1:0]          lo_clip;
    logic [PosWidth-1:0]          hi_clip;
    logic [PosWidth-1:0]          cfg_clamped;
    logic [AW-1:0]                addr_a;
    logic [AW-1:0]                addr_b;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    node_t                        wr_node;
    node_t                        q_t1;
    node_t                        q_t2;

    assign lo_clip = (in_range_low == '0) ? PosWidth'(1) : in_range_low;
    assign hi_clip = (in_range_high > liu_reg) ? liu_reg : in_range_high;

    always_comb
    begin
        cfg_clamped = cfg_value;
        if (cfg_value == '0)
        begin
            cfg_clamped = PosWidth'(1);
        end
        else if (32'(cfg_value) > 32'(LEAVES))
        begin
            cfg_clamped = PosWidth'(LEAVES);
        end
    end

    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        if (cmd.ins_rd)
        begin
            addr_a = {idx_reg[AW-1:1], 1'b0};
            addr_b = {idx_reg[AW-1:1], 1'b1};
        end
        else if (cmd.q_rd)
        begin
            addr_a = l_reg[AW-1:0];
            addr_b = AW'(r_reg - IW'(1));
        end
        else if (cmd.s_rd)
        begin
            addr_a = AW'(32'(LEAVES) + 32'(hi_reg) - 32'd1);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_node = '{m: EMPTY_MIN, c: '0};
        if (cmd.clr_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.ins_leaf)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg[AW-1:0];
            wr_node = '{m: val_reg, c: CW'(1)};
        end
        else if (cmd.ins_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_reg >> 1);
            wr_node = combine(rda_reg, rdb_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_min[wr_addr] <= wr_node.m;
            mem_cnt[wr_addr] <= wr_node.c;
        end
        rda_reg <= '{m: mem_min[addr_a], c: mem_cnt[addr_a]};
        rdb_reg <= '{m: mem_min[addr_b], c: mem_cnt[addr_b]};
    end

    assign q_t1 = l_reg[0] ? combine(acc_reg, rda_reg) : acc_reg;
    assign q_t2 = r_reg[0] ? combine(q_t1, rdb_reg) : q_t1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            liu_reg       <= PosWidth'(LiuReset);
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                liu_reg     <= cfg_clamped;
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            pos_reg   <= in_position;
            val_reg   <= in_leaf_value;
            thr_reg   <= in_threshold;
            lo_reg    <= lo_clip;
            hi_reg    <= hi_clip;
            idx_reg   <= IW'(32'(LEAVES) + 32'(in_position) - 32'd1);
            l_reg     <= IW'(32'(LEAVES) + 32'(lo_clip) - 32'd1);
            r_reg     <= IW'(32'(LEAVES) + 32'(hi_clip));
            acc_reg   <= '{m: EMPTY_MIN, c: '0};
            found_reg <= 1'b0;
            fpos_reg  <= '0;
        end
        if (cmd.ins_wr)
        begin
            idx_reg <= idx_reg >> 1;
        end
        if (cmd.q_comb)
        begin
            acc_reg <= q_t2;
            l_reg   <= (l_reg + IW'(l_reg[0])) >> 1;
            r_reg   <= r_reg >> 1;
        end
        if (cmd.s_cmp)
        begin
            if (status.s_hit)
            begin
                found_reg <= 1'b1;
                fpos_reg  <= hi_reg;
            end
            else if (status.s_more)
            begin
                hi_reg <= hi_reg - PosWidth'(1);
            end
        end
        if (cmd.out_load)
        begin
            case (kind_reg)
                KIND_QUERY:
                begin
                    out_min_reg   <= acc_reg.m;
                    out_cnt_reg   <= PosWidth'(acc_reg.c);
                    out_found_reg <= 1'b0;
                    out_fpos_reg  <= '0;
                end
                KIND_SEARCH:
                begin
                    out_min_reg   <= '0;
                    out_cnt_reg   <= '0;
                    out_found_reg <= found_reg;
                    out_fpos_reg  <= fpos_reg;
                end
                default:
                begin
                    out_min_reg   <= '0;
                    out_cnt_reg   <= '0;
                    out_found_reg <= 1'b0;
                    out_fpos_reg  <= '0;
                end
            endcase
        end
    end

    assign status.clr_done = (clr_cnt_reg == AW'(Depth - 1));
    assign status.kind     = kind_reg;
    assign status.ins_ok   = (pos_reg != '0) && (pos_reg <= liu_reg);
    assign status.range_ok = (lo_reg <= hi_reg);
    assign status.idx_gt1  = (idx_reg > IW'(1));
    assign status.l_lt_r   = (l_reg < r_reg);
    assign status.s_hit    = (rda_reg.m < thr_reg);
    assign status.s_more   = (hi_reg > lo_reg);
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid          = out_valid_reg;
    assign out_min_value      = out_min_reg;
    assign out_min_count      = out_cnt_reg;
    assign out_found          = out_found_reg;
    assign out_found_position = out_fpos_reg;

endmodule

// ----- rtl/min_count_segment_tree_unit.sv -----
// Insert, range query and search each step through the node memory with one node memory read
// per tree level or leaf.
// Throughput: one transfer in flight at a time; the next is taken once the result is registered.
// Reset and every configuration write start a clearing pass over all 2*LEAVES entries of the node
// memory, during which no input transfer is taken.
// Top level of the min-count segment tree unit.
module min_count_segment_tree_unit
    import mcst_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [PosWidth-1:0]     cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // position, leaf_value, range_low, range_high, threshold, zero fill
    input  logic [InDataWidth-1:0]  s_axis_tdata,
    // kind
    input  logic [KindWidth-1:0]    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // min_value, min_count, found, found_position, zero fill
    output logic [OutDataWidth-1:0] m_axis_tdata
);

    cmd_t                         cmd;
    status_t                      status;
    logic signed [ValueWidth-1:0] out_min_value;
    logic [PosWidth-1:0]          out_min_count;
    logic                         out_found;
    logic [PosWidth-1:0]          out_found_position;

    assign cfg_ready = 1'b1;

    mcst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .cfg_valid (cfg_valid),
        .status    (status),
        .in_ready  (s_axis_tready),
        .cmd       (cmd)
    );

    mcst_dpath #(
        .LEAVES (LEAVES)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_value          (cfg_data),
        .in_kind            (s_axis_tuser),
        .in_position        (s_axis_tdata[10:0]),
        .in_leaf_value      (s_axis_tdata[58:11]),
        .in_range_low       (s_axis_tdata[69:59]),
        .in_range_high      (s_axis_tdata[80:70]),
        .in_threshold       (s_axis_tdata[128:81]),
        .out_ready          (m_axis_tready),
        .out_valid          (m_axis_tvalid),
        .out_min_value      (out_min_value),
        .out_min_count      (out_min_count),
        .out_found          (out_found),
        .out_found_position (out_found_position)
    );

    assign m_axis_tdata = {1'b0, out_found_position, out_found, out_min_count, out_min_value};

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input taken while a transfer is still in progress.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_axis_tready)
        else $error("Input ready during the clearing pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[59] |-> m_axis_tdata[70:60] != 11'd0)
        else $error("Search reported found at position zero.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[59] |-> m_axis_tdata[70:60] == 11'd0)
        else $error("Search position set without a hit.");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the min-count segment tree unit.
module tb_top;
    import mcst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Leaves = 1024;
    localparam int QueueDepth = 1024;
    localparam logic [KindWidth-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [PosWidth-1:0]          found_position;
        logic                         found;
        logic [PosWidth-1:0]          min_count;
        logic signed [ValueWidth-1:0] min_value;
    } tree_result_t;

    class tree_scoreboard;
        logic signed [ValueWidth-1:0] node_min [2*Leaves];
        logic [PosWidth-1:0]          node_cnt [2*Leaves];
        int unsigned                  span;
        tree_result_t                 want_buf [QueueDepth];
        int unsigned                  head_idx;
        int unsigned                  tail_idx;
        int                           errors;

        function new();
            errors = 0;
            head_idx = 0;
            tail_idx = 0;
            set_span(Leaves);
        endfunction

        function int unsigned outstanding();
            return tail_idx - head_idx;
        endfunction

        function void set_span(int unsigned v);
            if (v < 1)
                v = 1;
            if (v > Leaves)
                v = Leaves;
            span = v;
            foreach (node_min[i])
            begin
                node_min[i] = EMPTY_MIN;
                node_cnt[i] = '0;
            end
        endfunction

        function void merge(inout logic signed [ValueWidth-1:0] m, inout logic [PosWidth-1:0] c,
                            input logic signed [ValueWidth-1:0] m2,
                            input logic [PosWidth-1:0] c2);
            if (m2 < m)
            begin
                m = m2;
                c = c2;
            end
            else if (m2 == m)
                c = c + c2;
        endfunction

        function void note_request(logic [KindWidth-1:0] kind, logic [PosWidth-1:0] pos,
                                   logic signed [ValueWidth-1:0] val,
                                   logic [PosWidth-1:0] lo_in, logic [PosWidth-1:0] hi_in,
                                   logic signed [ValueWidth-1:0] thr);
            tree_result_t r;
            int unsigned lo, hi, i, l, rr, p;
            logic signed [ValueWidth-1:0] m;
            logic [PosWidth-1:0] c;
            r = '0;
            lo = (lo_in < 1) ? 1 : lo_in;
            hi = (hi_in > span) ? span : hi_in;
            if (kind == KIND_INSERT)
            begin
                if (pos >= 1 && pos <= span)
                begin
                    i = Leaves + pos - 1;
                    node_min[i] = val;
                    node_cnt[i] = 1;
                    while (i > 1)
                    begin
                        i = i >> 1;
                        m = node_min[2*i];
                        c = node_cnt[2*i];
                        merge(m, c, node_min[2*i+1], node_cnt[2*i+1]);
                        node_min[i] = m;
                        node_cnt[i] = c;
                    end
                end
            end
            else if (kind == KIND_QUERY)
            begin
                m = EMPTY_MIN;
                c = '0;
                if (lo <= hi)
                begin
                    l = Leaves + lo - 1;
                    rr = Leaves + hi;
                    while (l < rr)
                    begin
                        if (l[0])
                        begin
                            merge(m, c, node_min[l], node_cnt[l]);
                            l++;
                        end
                        if (rr[0])
                        begin
                            rr--;
                            merge(m, c, node_min[rr], node_cnt[rr]);
                        end
                        l = l >> 1;
                        rr = rr >> 1;
                    end
                end
                r.min_value = m;
                r.min_count = c;
            end
            else if (kind == KIND_SEARCH)
            begin
                for (p = hi; p >= lo && p >= 1; p--)
                begin
                    if (node_min[Leaves + p - 1] < thr)
                    begin
                        r.found = 1'b1;
                        r.found_position = PosWidth'(p);
                        break;
                    end
                end
            end
            want_buf[tail_idx % QueueDepth] = r;
            tail_idx++;
        endfunction

        function void check_result(tree_result_t got);
            tree_result_t want;
            if (outstanding() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer %h", got);
                return;
            end
            want = want_buf[head_idx % QueueDepth];
            head_idx++;
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display({"result error: expected val %0d cnt %0d fnd %0d pos %0d,",
                              " got val %0d cnt %0d fnd %0d pos %0d"},
                             want.min_value, want.min_count, want.found, want.found_position,
                             got.min_value, got.min_count, got.found, got.found_position);
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [PosWidth-1:0]     cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [InDataWidth-1:0]  s_axis_tdata;
    logic [KindWidth-1:0]    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OutDataWidth-1:0] m_axis_tdata;

    tree_scoreboard board;
    int send_idle_pct;
    int stall_pct;
    int unsigned span_now;

    min_count_segment_tree_unit #(.LEAVES(Leaves)) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("min_count_segment_tree_unit: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(tree_result_t'(m_axis_tdata[OutDataWidth-1-1:0]));
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_request(logic [KindWidth-1:0] kind, logic [PosWidth-1:0] pos,
                                logic signed [ValueWidth-1:0] val, logic [PosWidth-1:0] lo,
                                logic [PosWidth-1:0] hi, logic signed [ValueWidth-1:0] thr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'b0, thr, hi, lo, val, pos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(kind, pos, val, lo, hi, thr);
        @(negedge clk);
    endtask

    task automatic write_span(logic [PosWidth-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_span(v);
        span_now = board.span;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PosWidth-1:0] pick_pos();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return PosWidth'($urandom_range(2047));
        if (r < 10)
            return PosWidth'($urandom_range(span_now + 2, 0));
        return PosWidth'($urandom_range(span_now, 1));
    endfunction

    function automatic logic signed [ValueWidth-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $signed(ValueWidth'($urandom_range(20))) - 10;
        if (r < 55)
            return EMPTY_MIN;
        if (r < 60)
            return {1'b1, {(ValueWidth-1){1'b0}}};
        return ValueWidth'({$urandom(), $urandom()});
    endfunction

    task automatic random_phase(int count);
        int k;
        logic [KindWidth-1:0] kind;
        logic [PosWidth-1:0] a;
        logic [PosWidth-1:0] b;
        for (k = 0; k < count; k++)
        begin
            kind = ($urandom_range(19) == 0) ? KIND_UNUSED : KindWidth'($urandom_range(2));
            a = pick_pos();
            b = pick_pos();
            if ($urandom_range(3) != 0 && a > b)
            begin
                a = a ^ b;
                b = a ^ b;
                a = a ^ b;
            end
            if (kind == KIND_SEARCH && $urandom_range(1) == 0)
                a = (b > 40) ? PosWidth'(b - $urandom_range(40)) : a;
            send_request(kind, pick_pos(), pick_value(), a, b, pick_value());
        end
    endtask

    initial
    begin
        board = new();
        span_now = Leaves;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        send_request(KIND_QUERY, 0, 0, 0, 1024, 0);
        send_request(KIND_INSERT, 1, {1'b1, 47'd0}, 0, 0, 0);
        send_request(KIND_INSERT, 1024, EMPTY_MIN, 0, 0, 0);
        send_request(KIND_INSERT, 0, 5, 0, 0, 0);
        send_request(KIND_INSERT, 1025, 5, 0, 0, 0);
        send_request(KIND_INSERT, 2047, 5, 0, 0, 0);
        send_request(KIND_INSERT, 500, -7, 0, 0, 0);
        send_request(KIND_INSERT, 501, -7, 0, 0, 0);
        send_request(KIND_QUERY, 0, 0, 1, 1024, 0);
        send_request(KIND_QUERY, 0, 0, 2, 1023, 0);
        send_request(KIND_QUERY, 0, 0, 1025, 1024, 0);
        send_request(KIND_QUERY, 0, 0, 2047, 2047, 0);
        send_request(KIND_SEARCH, 0, 0, 0, 2047, EMPTY_MIN);
        send_request(KIND_SEARCH, 0, 0, 400, 600, 0);
        send_request(KIND_SEARCH, 0, 0, 400, 499, 0);
        send_request(KIND_SEARCH, 0, 0, 600, 400, 0);
        send_request(KIND_SEARCH, 0, 0, 1, 3, {1'b1, 47'd0});
        send_request(KIND_UNUSED, 2047, -1, 2047, 2047, -1);

        write_span(0);
        send_request(KIND_INSERT, 1, 3, 0, 0, 0);
        send_request(KIND_INSERT, 2, 3, 0, 0, 0);
        send_request(KIND_QUERY, 0, 0, 0, 2047, 0);
        random_phase(20);

        write_span(2047);
        random_phase(60);
        write_span(13);
        send_idle_pct = 63;
        random_phase(110);
        write_span(16);
        send_idle_pct = 0;
        stall_pct = 63;
        random_phase(110);
        write_span(PosWidth'($urandom_range(1000, 2)));
        send_idle_pct = 35;
        stall_pct = 35;
        random_phase(110);

        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (board.errors == 0)
            $display("min_count_segment_tree_unit: match");
        else
            $display("min_count_segment_tree_unit: mismatch");
        $finish;
    end
endmodule
